>>> design/knnhr_pkg.sv
// knnhr_pkg: shared constants, codes and types of the point height roughness classifier.
// Used by every module of the block but knnhr_ram; depends on nothing.
`timescale 1ns / 1ps

package knnhr_pkg;

   // default sizes, handed down as top level parameters
   localparam int MAX_POINTS_DEF    = 1024;
   localparam int MAX_NEIGHBORS_DEF = 32;
   localparam int COORD_BITS_DEF    = 20;

   // fixed field widths
   localparam int IDX_W     = 10;
   localparam int COL_W     = 8;
   localparam int THR_W     = 16;
   localparam int NCFG_W    = 6;
   localparam int K_W       = 7;   // holds neighbour counts up to 127
   localparam int CSR_IDX_W = 2;

   // request function codes
   localparam logic [1:0] FUNC_LOAD     = 2'd0;
   localparam logic [1:0] FUNC_CLASSIFY = 2'd1;
   localparam logic [1:0] FUNC_CLEAR    = 2'd2;

   // result classes
   localparam logic [1:0] CLASS_CORNER  = 2'd0;
   localparam logic [1:0] CLASS_PLANAR  = 2'd1;
   localparam logic [1:0] CLASS_NEITHER = 2'd2;
   localparam logic [1:0] CLASS_INVALID = 2'd3;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NEIGHBOR_COUNT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CORNER_THRESHOLD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANAR_THRESHOLD = 2'd2;

   localparam logic [NCFG_W-1:0] NCOUNT_RESET  = 6'd20;
   localparam logic [THR_W-1:0]  CORNER_RESET  = 16'd150;
   localparam logic [THR_W-1:0]  PLANAR_RESET  = 16'd50;
   localparam logic [COL_W-1:0]  COL_FULL      = 8'd255;

   // control from the sequencer to the nearest list
   typedef struct packed {
      logic           clr;
      logic [K_W-1:0] k;
   } knnhr_lctl_type;

endpackage

>>> design/knnhr_ram.sv
// knnhr_ram: generic single write, single read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module knnhr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

>>> design/knnhr_dist.sv
// knnhr_dist: pipelined squared distance unit, one point pair a cycle, three stages.
// Depends on knnhr_pkg.
`timescale 1ns / 1ps

module knnhr_dist
   import knnhr_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic signed [COORD_BITS-1:0]  p_x,
   input  logic signed [COORD_BITS-1:0]  p_y,
   input  logic signed [COORD_BITS-1:0]  p_z,
   input  logic signed [COORD_BITS-1:0]  q_x,
   input  logic signed [COORD_BITS-1:0]  q_y,
   input  logic signed [COORD_BITS-1:0]  q_z,
   output logic                          out_valid,
   output logic [2*COORD_BITS+3:0]       sq_dist,
   output logic signed [COORD_BITS-1:0]  height,
   output logic                          busy
);

   localparam int CB = COORD_BITS;
   localparam int SQ = 2*CB+2;
   localparam int DW = 2*CB+4;

   logic signed [CB:0] dx, dy, dz;
   logic [CB:0]        ax_in, ay_in, az_in;
   logic [CB:0]        ax_ff, ay_ff, az_ff;
   logic [SQ-1:0]      sx_in, sy_in, sz_in;
   logic [SQ-1:0]      sx_ff, sy_ff, sz_ff;
   logic [DW-1:0]      dist_in, dist_ff;
   logic signed [CB-1:0] z1_ff, z2_ff, z3_ff;
   logic               v1_ff, v2_ff, v3_ff;

   // stage 1: absolute differences
   assign dx = $signed({q_x[CB-1], q_x}) - $signed({p_x[CB-1], p_x});
   assign dy = $signed({q_y[CB-1], q_y}) - $signed({p_y[CB-1], p_y});
   assign dz = $signed({q_z[CB-1], q_z}) - $signed({p_z[CB-1], p_z});
   assign ax_in = dx[CB] ? $unsigned(-dx) : $unsigned(dx);
   assign ay_in = dy[CB] ? $unsigned(-dy) : $unsigned(dy);
   assign az_in = dz[CB] ? $unsigned(-dz) : $unsigned(dz);

   // stage 2: squares
   assign sx_in = SQ'(ax_ff) * SQ'(ax_ff);
   assign sy_in = SQ'(ay_ff) * SQ'(ay_ff);
   assign sz_in = SQ'(az_ff) * SQ'(az_ff);

   // stage 3: sum
   assign dist_in = DW'(sx_ff) + DW'(sy_ff) + DW'(sz_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      ax_ff   <= ax_in;
      ay_ff   <= ay_in;
      az_ff   <= az_in;
      z1_ff   <= q_z;
      sx_ff   <= sx_in;
      sy_ff   <= sy_in;
      sz_ff   <= sz_in;
      z2_ff   <= z1_ff;
      dist_ff <= dist_in;
      z3_ff   <= z2_ff;
   end

   assign out_valid = v3_ff;
   assign sq_dist   = dist_ff;
   assign height    = z3_ff;
   assign busy      = v1_ff | v2_ff | v3_ff;

endmodule

>>> design/knnhr_list.sv
// knnhr_list: sorted list of the k nearest distances with their heights, one insert a cycle.
// Depends on knnhr_pkg.
`timescale 1ns / 1ps

module knnhr_list
   import knnhr_pkg::*;
#(
   parameter int MAX_NEIGHBORS = MAX_NEIGHBORS_DEF,
   parameter int COORD_BITS    = COORD_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  knnhr_lctl_type                        lctl,
   input  logic                                  in_valid,
   input  logic [2*COORD_BITS+3:0]               in_dist,
   input  logic signed [COORD_BITS-1:0]          in_height,
   input  logic [(MAX_NEIGHBORS>1 ? $clog2(MAX_NEIGHBORS) : 1)-1:0] sel,
   output logic signed [COORD_BITS-1:0]          sel_height,
   output logic [K_W-1:0]                        kept
);

   localparam int DW = 2*COORD_BITS+4;

   logic [DW-1:0]                dist_ff [MAX_NEIGHBORS];
   logic [DW-1:0]                dist_in [MAX_NEIGHBORS];
   logic signed [COORD_BITS-1:0] hgt_ff  [MAX_NEIGHBORS];
   logic signed [COORD_BITS-1:0] hgt_in  [MAX_NEIGHBORS];
   logic [MAX_NEIGHBORS-1:0]     gt, gt_prev;
   logic [K_W-1:0]               kept_ff, kept_in;

   // an entry moves when it is empty or farther than the new word; ties stay ahead
   always_comb begin
      for (int j = 0; j < MAX_NEIGHBORS; j++) begin
         gt[j] = (K_W'(j) >= kept_ff) || (dist_ff[j] > in_dist);
      end
      gt_prev[0] = 1'b0;
      for (int j = 1; j < MAX_NEIGHBORS; j++) begin
         gt_prev[j] = gt[j-1];
      end
      for (int j = 0; j < MAX_NEIGHBORS; j++) begin
         dist_in[j] = dist_ff[j];
         hgt_in[j]  = hgt_ff[j];
         if (in_valid && (K_W'(j) < lctl.k) && gt[j]) begin
            if (!gt_prev[j]) begin
               dist_in[j] = in_dist;
               hgt_in[j]  = in_height;
            end else begin
               dist_in[j] = dist_ff[(j > 0) ? j-1 : 0];
               hgt_in[j]  = hgt_ff[(j > 0) ? j-1 : 0];
            end
         end
      end
   end

   // fill count
   always_comb begin
      kept_in = kept_ff;
      if (lctl.clr) begin
         kept_in = '0;
      end else if (in_valid && (kept_ff < lctl.k)) begin
         kept_in = kept_ff + K_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kept_ff <= '0;
      end else begin
         kept_ff <= kept_in;
      end
      for (int j = 0; j < MAX_NEIGHBORS; j++) begin
         dist_ff[j] <= dist_in[j];
         hgt_ff[j]  <= hgt_in[j];
      end
   end

   assign sel_height = hgt_ff[sel];
   assign kept       = kept_ff;

endmodule

>>> design/knn_height_roughness_classifier.sv
// knn_height_roughness_classifier: top level, sequencer, height statistics and result stage.
// Depends on knnhr_pkg, knnhr_ram, knnhr_dist and knnhr_list.
//
//  channel | ports                         | direction | carries
//  --------+-------------------------------+-----------+-------------------------------
//  req     | req_valid/req_ready, req_*    | in        | load, classify or clear word
//  rsp     | rsp_valid/rsp_ready, rsp_*    | out       | class and recoloured point
//  csr     | csr_valid/csr_ready, csr_*    | in        | register index and write data
//
// Load and clear are taken and completed in the idle state. A classify reads each stored
// point from memory through the distance pipeline, then passes each neighbour height
// through the accumulator, then forms the final products.
// An index not loaded is answered without a search. Reset is synchronous and clears control
// state only; no clearing pass is needed. A waiting result does not block new loads,
// and a finished classify holds until the previous result has been taken.
`timescale 1ns / 1ps

module knn_height_roughness_classifier
   import knnhr_pkg::*;
#(
   parameter int MAX_POINTS    = MAX_POINTS_DEF,
   parameter int MAX_NEIGHBORS = MAX_NEIGHBORS_DEF,
   parameter int COORD_BITS    = COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_func,
   input  logic [IDX_W-1:0]             req_point_index,
   input  logic signed [COORD_BITS-1:0] req_pos_x,
   input  logic signed [COORD_BITS-1:0] req_pos_y,
   input  logic signed [COORD_BITS-1:0] req_pos_z,
   input  logic [COL_W-1:0]             req_red_in,
   input  logic [COL_W-1:0]             req_green_in,
   input  logic [COL_W-1:0]             req_blue_in,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [IDX_W-1:0]             rsp_result_index,
   output logic [1:0]                   rsp_point_class,
   output logic signed [COORD_BITS-1:0] rsp_out_x,
   output logic signed [COORD_BITS-1:0] rsp_out_y,
   output logic signed [COORD_BITS-1:0] rsp_out_z,
   output logic [COL_W-1:0]             rsp_red_out,
   output logic [COL_W-1:0]             rsp_green_out,
   output logic [COL_W-1:0]             rsp_blue_out,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [THR_W-1:0]             csr_data
);

   localparam int CB    = COORD_BITS;
   localparam int AW    = $clog2(MAX_POINTS);
   localparam int PLW   = $clog2(MAX_POINTS+1);
   localparam int DW    = 2*CB+4;
   localparam int LW    = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
   localparam int S1W   = CB+7;
   localparam int S2W   = 2*CB+6;
   localparam int ZSQW  = 2*CB;
   localparam int DEVW  = 2*CB+14;
   localparam int TW    = K_W+THR_W;
   localparam int CMPW  = (DEVW > 2*TW) ? DEVW : 2*TW;
   localparam int CW    = 3*COL_W;

   typedef enum logic [3:0] {
      ST_IDLE, ST_TARGET, ST_SCAN, ST_DRAIN, ST_SUM, ST_SUM_END,
      ST_FIN_MUL, ST_FIN_SUB, ST_FIN_SQ, ST_DONE
   } state_type;

   state_type state_ff;

   logic [NCFG_W-1:0] ncount_ff;
   logic [THR_W-1:0]  corner_ff, planar_ff;
   logic [PLW-1:0]    loaded_ff;
   logic [PLW-1:0]    scan_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic              inval_ff;
   logic [K_W-1:0]    k_ff, k_in;
   logic [K_W-1:0]    sum_cnt_ff;
   logic              issue_ff;
   logic signed [CB-1:0] px_ff, py_ff, pz_ff;
   logic [CW-1:0]     col_ff;

   logic              sv_ff;
   logic signed [CB-1:0] zq_ff;
   logic [ZSQW-1:0]   zsq_ff, zsq_in;
   logic signed [S1W-1:0] s1_ff;
   logic [S2W-1:0]    s2_ff;
   logic [S1W-1:0]    s1_abs;
   logic [DEVW-1:0]   a_ff, b_ff, dev_ff;
   logic [TW-1:0]     ct_ff, pt_ff;
   logic [2*TW-1:0]   ctsq_ff, ptsq_ff;
   logic [1:0]        cls;

   logic              req_fire, idx_ok, load_ok, rsp_load;
   logic              ram_wr;
   logic [AW-1:0]     ram_rd_addr;
   logic [3*CB-1:0]   coord_rd;
   logic [CW-1:0]     color_rd;

   logic              dv, dbusy;
   logic [DW-1:0]     dd;
   logic signed [CB-1:0] dz;
   logic signed [CB-1:0] zsel;
   logic [K_W-1:0]    kept;
   knnhr_lctl_type    lctl;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && req_ready;
   assign idx_ok    = 32'(req_point_index) < 32'(loaded_ff);
   assign load_ok   = 32'(loaded_ff) < MAX_POINTS;
   assign ram_wr    = req_fire && (req_func == FUNC_LOAD) && load_ok;
   assign ram_rd_addr = (state_ff == ST_SCAN) ? scan_ff[AW-1:0] : AW'(req_point_index);
   // result register takes a new word when empty or being emptied
   assign rsp_load  = (state_ff == ST_DONE) && (!rsp_valid || rsp_ready);

   // stores: coordinates as {z, y, x}, colour as {r, g, b}
   knnhr_ram #(.WIDTH(3*CB), .DEPTH(MAX_POINTS)) u_coord_ram (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (loaded_ff[AW-1:0]),
      .wr_data ({req_pos_z, req_pos_y, req_pos_x}),
      .rd_addr (ram_rd_addr),
      .rd_data (coord_rd)
   );

   knnhr_ram #(.WIDTH(CW), .DEPTH(MAX_POINTS)) u_color_ram (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (loaded_ff[AW-1:0]),
      .wr_data ({req_red_in, req_green_in, req_blue_in}),
      .rd_addr (ram_rd_addr),
      .rd_data (color_rd)
   );

   // distance unit fed straight from the store read port
   knnhr_dist #(.COORD_BITS(CB)) u_dist (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (issue_ff),
      .p_x       (px_ff),
      .p_y       (py_ff),
      .p_z       (pz_ff),
      .q_x       ($signed(coord_rd[CB-1:0])),
      .q_y       ($signed(coord_rd[2*CB-1:CB])),
      .q_z       ($signed(coord_rd[3*CB-1:2*CB])),
      .out_valid (dv),
      .sq_dist   (dd),
      .height    (dz),
      .busy      (dbusy)
   );

   assign lctl.clr = (state_ff == ST_TARGET);
   assign lctl.k   = k_ff;

   knnhr_list #(.MAX_NEIGHBORS(MAX_NEIGHBORS), .COORD_BITS(CB)) u_list (
      .clock      (clock),
      .reset      (reset),
      .lctl       (lctl),
      .in_valid   (dv),
      .in_dist    (dd),
      .in_height  (dz),
      .sel        (sum_cnt_ff[LW-1:0]),
      .sel_height (zsel),
      .kept       (kept)
   );

   // neighbour count: at least one, at most the list depth and the points loaded
   always_comb begin
      int kc;
      kc = int'(ncount_ff);
      if (kc < 1) kc = 1;
      if (kc > MAX_NEIGHBORS) kc = MAX_NEIGHBORS;
      if (kc > int'(loaded_ff)) kc = int'(loaded_ff);
      k_in = K_W'(kc);
   end

   // height square for the accumulator
   assign zsq_in = zsel[CB-1] ? ZSQW'($unsigned(-zsel)) * ZSQW'($unsigned(-zsel))
                              : ZSQW'($unsigned(zsel)) * ZSQW'($unsigned(zsel));
   assign s1_abs = s1_ff[S1W-1] ? $unsigned(-s1_ff) : $unsigned(s1_ff);

   // deviation against squared scaled thresholds
   always_comb begin
      if (CMPW'(dev_ff) > CMPW'(ctsq_ff)) begin
         cls = CLASS_CORNER;
      end else if (CMPW'(dev_ff) < CMPW'(ptsq_ff)) begin
         cls = CLASS_PLANAR;
      end else begin
         cls = CLASS_NEITHER;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ncount_ff <= NCOUNT_RESET;
         corner_ff <= CORNER_RESET;
         planar_ff <= PLANAR_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_NEIGHBOR_COUNT:   ncount_ff <= csr_data[NCFG_W-1:0];
            CSR_CORNER_THRESHOLD: corner_ff <= csr_data;
            CSR_PLANAR_THRESHOLD: planar_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // sequencer, datapath registers and result word
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         loaded_ff <= '0;
         issue_ff  <= 1'b0;
         sv_ff     <= 1'b0;
         rsp_valid <= 1'b0;
      end else begin
         issue_ff <= 1'b0;
         sv_ff    <= 1'b0;
         if (rsp_valid && rsp_ready && !rsp_load) begin
            rsp_valid <= 1'b0;
         end
         if (sv_ff) begin
            s1_ff <= s1_ff + S1W'(zq_ff);
            s2_ff <= s2_ff + S2W'(zsq_ff);
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  case (req_func)
                     FUNC_LOAD: begin
                        if (load_ok) loaded_ff <= loaded_ff + PLW'(1);
                     end
                     FUNC_CLASSIFY: begin
                        idx_ff   <= req_point_index;
                        inval_ff <= !idx_ok;
                        state_ff <= idx_ok ? ST_TARGET : ST_DONE;
                     end
                     FUNC_CLEAR: loaded_ff <= '0;
                     default: ;
                  endcase
               end
            end
            ST_TARGET: begin
               px_ff    <= $signed(coord_rd[CB-1:0]);
               py_ff    <= $signed(coord_rd[2*CB-1:CB]);
               pz_ff    <= $signed(coord_rd[3*CB-1:2*CB]);
               col_ff   <= color_rd;
               k_ff     <= k_in;
               scan_ff  <= '0;
               s1_ff    <= '0;
               s2_ff    <= '0;
               state_ff <= ST_SCAN;
            end
            ST_SCAN: begin
               issue_ff <= 1'b1;
               scan_ff  <= scan_ff + PLW'(1);
               if ((scan_ff + PLW'(1)) == loaded_ff) state_ff <= ST_DRAIN;
            end
            ST_DRAIN: begin
               sum_cnt_ff <= '0;
               if (!issue_ff && !dbusy) state_ff <= ST_SUM;
            end
            ST_SUM: begin
               zq_ff      <= zsel;
               zsq_ff     <= zsq_in;
               sv_ff      <= 1'b1;
               sum_cnt_ff <= sum_cnt_ff + K_W'(1);
               if ((sum_cnt_ff + K_W'(1)) == kept) state_ff <= ST_SUM_END;
            end
            ST_SUM_END: state_ff <= ST_FIN_MUL;
            ST_FIN_MUL: begin
               a_ff     <= DEVW'(s2_ff) * DEVW'(kept);
               b_ff     <= DEVW'(s1_abs) * DEVW'(s1_abs);
               state_ff <= ST_FIN_SUB;
            end
            ST_FIN_SUB: begin
               dev_ff   <= a_ff - b_ff;
               ct_ff    <= TW'(kept) * TW'(corner_ff);
               pt_ff    <= TW'(kept) * TW'(planar_ff);
               state_ff <= ST_FIN_SQ;
            end
            ST_FIN_SQ: begin
               ctsq_ff  <= (2*TW)'(ct_ff) * (2*TW)'(ct_ff);
               ptsq_ff  <= (2*TW)'(pt_ff) * (2*TW)'(pt_ff);
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (rsp_load) begin
                  rsp_valid        <= 1'b1;
                  rsp_result_index <= idx_ff;
                  state_ff         <= ST_IDLE;
                  if (inval_ff) begin
                     rsp_point_class <= CLASS_INVALID;
                     rsp_out_x       <= '0;
                     rsp_out_y       <= '0;
                     rsp_out_z       <= '0;
                     rsp_red_out     <= '0;
                     rsp_green_out   <= '0;
                     rsp_blue_out    <= '0;
                  end else begin
                     rsp_point_class <= cls;
                     rsp_out_x       <= px_ff;
                     rsp_out_y       <= py_ff;
                     rsp_out_z       <= pz_ff;
                     case (cls)
                        CLASS_CORNER: begin
                           rsp_red_out   <= COL_FULL;
                           rsp_green_out <= '0;
                           rsp_blue_out  <= '0;
                        end
                        CLASS_PLANAR: begin
                           rsp_red_out   <= '0;
                           rsp_green_out <= COL_FULL;
                           rsp_blue_out  <= '0;
                        end
                        default: begin
                           rsp_red_out   <= col_ff[3*COL_W-1:2*COL_W];
                           rsp_green_out <= col_ff[2*COL_W-1:COL_W];
                           rsp_blue_out  <= col_ff[COL_W-1:0];
                        end
                     endcase
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // the scan fills the list to exactly k before summing starts
   a_list_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUM) |-> (kept == k_ff))
      else $error("nearest list not full at summing");

   // the scan never addresses past the loaded points
   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (scan_ff < loaded_ff))
      else $error("scan address beyond loaded points");

   // a new result only appears out of the done state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside done state");

   // the distance pipeline is empty once summing runs
   a_dist_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUM) |-> (!dbusy && !issue_ff))
      else $error("distance unit busy during summing");

endmodule

>>> bench/tb.sv
// tb: self-checking bench for knn_height_roughness_classifier.
// Loads point frames, classifies points against an in-bench model of the neighbour
// height deviation and checks every result word; depends on knnhr_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
   import knnhr_pkg::*;

   localparam int NPTS = 1024;
   localparam int NNB = 32;
   localparam int CB = 20;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int RANDOM_WORDS = 480;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct {
      logic [1:0]             func;
      logic [IDX_W-1:0]       idx;
      logic signed [CB-1:0]   x, y, z;
      logic [COL_W-1:0]       r, g, b;
   } req_word_t;

   typedef struct {
      logic [IDX_W-1:0]       idx;
      logic [1:0]             cls;
      logic signed [CB-1:0]   x, y, z;
      logic [COL_W-1:0]       r, g, b;
   } verdict_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [1:0]           req_func = FUNC_LOAD;
   logic [IDX_W-1:0]     req_point_index = '0;
   logic signed [CB-1:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic [COL_W-1:0]     req_red_in = '0, req_green_in = '0, req_blue_in = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [IDX_W-1:0]     rsp_result_index;
   logic [1:0]           rsp_point_class;
   logic signed [CB-1:0] rsp_out_x, rsp_out_y, rsp_out_z;
   logic [COL_W-1:0]     rsp_red_out, rsp_green_out, rsp_blue_out;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_NEIGHBOR_COUNT;
   logic [THR_W-1:0]     csr_data = '0;

   knn_height_roughness_classifier uut (.*);

   // model state
   logic signed [CB-1:0] store_x [NPTS];
   logic signed [CB-1:0] store_y [NPTS];
   logic signed [CB-1:0] store_z [NPTS];
   logic [COL_W-1:0]     store_r [NPTS];
   logic [COL_W-1:0]     store_g [NPTS];
   logic [COL_W-1:0]     store_b [NPTS];
   int                   frame_size = 0;
   logic [NCFG_W-1:0]    k_reg = NCOUNT_RESET;
   logic [THR_W-1:0]     corner_reg = CORNER_RESET;
   logic [THR_W-1:0]     planar_reg = PLANAR_RESET;

   req_word_t request_words[$];
   verdict_t  pending_verdicts[$];
   int        words_queued = 0;
   int        words_taken = 0;
   int        fail_count = 0;
   int        cycle_count = 0;
   logic      req_took = 1'b0;
   logic      csr_took = 1'b0;
   logic      calm = 1'b0;
   int        hold_asked = 0;
   int        hold_served = 0;

   initial forever #4 clock = ~clock;

   // neighbour search and height deviation for one stored point
   function automatic verdict_t judge_point(logic [IDX_W-1:0] idx);
      verdict_t v;
      longint unsigned dist_list[NNB];
      longint hgt_list[NNB];
      int k, kept, pos;
      longint dx, dy, dz, s1, a1;
      longint unsigned d, s2, n, dev, ct, pt;
      v = '{idx: idx, cls: CLASS_INVALID, x: '0, y: '0, z: '0, r: '0, g: '0, b: '0};
      if (idx >= frame_size) return v;
      k = (k_reg == 0) ? 1 : int'(k_reg);
      if (k > NNB) k = NNB;
      if (k > frame_size) k = frame_size;
      kept = 0;
      for (int i = 0; i < frame_size; i++) begin
         dx = longint'(store_x[idx]) - longint'(store_x[i]);
         dy = longint'(store_y[idx]) - longint'(store_y[i]);
         dz = longint'(store_z[idx]) - longint'(store_z[i]);
         d = dx * dx + dy * dy + dz * dz;
         if (kept == k && d >= dist_list[k-1]) continue;
         pos = (kept < k) ? kept : k - 1;
         while (pos > 0 && dist_list[pos-1] > d) begin
            dist_list[pos] = dist_list[pos-1];
            hgt_list[pos] = hgt_list[pos-1];
            pos--;
         end
         dist_list[pos] = d;
         hgt_list[pos] = longint'(store_z[i]);
         if (kept < k) kept++;
      end
      s1 = 0;
      s2 = 0;
      for (int j = 0; j < kept; j++) begin
         s1 += hgt_list[j];
         s2 += hgt_list[j] * hgt_list[j];
      end
      n = kept;
      a1 = (s1 < 0) ? -s1 : s1;
      dev = n * s2 - a1 * a1;
      ct = n * corner_reg;
      pt = n * planar_reg;
      v.x = store_x[idx];
      v.y = store_y[idx];
      v.z = store_z[idx];
      if (dev > ct * ct) begin
         v.cls = CLASS_CORNER; v.r = COL_FULL; v.g = '0; v.b = '0;
      end else if (dev < pt * pt) begin
         v.cls = CLASS_PLANAR; v.r = '0; v.g = COL_FULL; v.b = '0;
      end else begin
         v.cls = CLASS_NEITHER; v.r = store_r[idx]; v.g = store_g[idx]; v.b = store_b[idx];
      end
      return v;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d, want %0d at cycle %0d", what, got, want, cycle_count);
      fail_count++;
   endtask

   // model update, result check and cycle limit
   always @(posedge clock) begin : observe
      verdict_t v;
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         req_took <= !reset && req_valid && req_ready;
         csr_took <= !reset && csr_valid && csr_ready;
         if (!reset && csr_valid && csr_ready) begin
            case (csr_index)
               CSR_NEIGHBOR_COUNT:   k_reg = csr_data[NCFG_W-1:0];
               CSR_CORNER_THRESHOLD: corner_reg = csr_data;
               CSR_PLANAR_THRESHOLD: planar_reg = csr_data;
               default: ;
            endcase
         end
         if (!reset && req_valid && req_ready) begin
            words_taken++;
            case (req_func)
               FUNC_LOAD: if (frame_size < NPTS) begin
                  store_x[frame_size] = req_pos_x;
                  store_y[frame_size] = req_pos_y;
                  store_z[frame_size] = req_pos_z;
                  store_r[frame_size] = req_red_in;
                  store_g[frame_size] = req_green_in;
                  store_b[frame_size] = req_blue_in;
                  frame_size++;
               end
               FUNC_CLEAR: frame_size = 0;
               FUNC_CLASSIFY: pending_verdicts = {pending_verdicts, judge_point(req_point_index)};
               default: ;
            endcase
         end
         if (!reset && rsp_valid && rsp_ready) begin
            if (pending_verdicts.size() == 0) begin
               report_mismatch("unexpected result, index", rsp_result_index, -1);
            end else begin
               v = pending_verdicts.pop_front();
               if (rsp_result_index !== v.idx) report_mismatch("index", rsp_result_index, v.idx);
               if (rsp_point_class !== v.cls) report_mismatch("class", rsp_point_class, v.cls);
               if (rsp_out_x !== v.x) report_mismatch("x", rsp_out_x, v.x);
               if (rsp_out_y !== v.y) report_mismatch("y", rsp_out_y, v.y);
               if (rsp_out_z !== v.z) report_mismatch("z", rsp_out_z, v.z);
               if (rsp_red_out !== v.r) report_mismatch("red", rsp_red_out, v.r);
               if (rsp_green_out !== v.g) report_mismatch("green", rsp_green_out, v.g);
               if (rsp_blue_out !== v.b) report_mismatch("blue", rsp_blue_out, v.b);
            end
         end
      end
   end

   // request driver: holds a word until taken, idles at random
   always @(negedge clock) begin : drive
      req_word_t w;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && !req_took)) begin
         if (request_words.size() != 0 && (calm || $urandom_range(99) >= 13)) begin
            w = request_words.pop_front();
            req_valid <= 1'b1;
            req_func <= w.func;
            req_point_index <= w.idx;
            req_pos_x <= w.x;
            req_pos_y <= w.y;
            req_pos_z <= w.z;
            req_red_in <= w.r;
            req_green_in <= w.g;
            req_blue_in <= w.b;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result receiver: random stalls plus an occasional long hold-off
   int hold_left = 0;
   always @(negedge clock) begin
      if (hold_served != hold_asked) begin
         hold_served <= hold_asked;
         hold_left <= 400;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || $urandom_range(99) >= 13;
      end
   end

   function automatic void push_word(logic [1:0] f, int idx,
                                     int x, int y, int z, int col);
      req_word_t w;
      w.func = f;
      w.idx = IDX_W'(idx);
      w.x = CB'(x);
      w.y = CB'(y);
      w.z = CB'(z);
      {w.r, w.g, w.b} = 24'(col);
      request_words = {request_words, w};
      words_queued++;
   endfunction

   // point near a base position; one in eight with fully random fields
   function automatic void push_point(int bx, int by, int bz, int xy_span, int z_span);
      if ($urandom_range(7) == 0)
         push_word(FUNC_LOAD, $urandom, $urandom, $urandom, $urandom, $urandom);
      else
         push_word(FUNC_LOAD, $urandom, bx + $urandom_range(xy_span), by + $urandom_range(xy_span),
                   bz + $urandom_range(z_span), $urandom);
   endfunction

   function automatic void push_classify(int idx);
      push_word(FUNC_CLASSIFY, idx, $urandom, $urandom, $urandom, $urandom);
   endfunction

   // wait until all words are taken and all results back, then let loads drain
   task automatic settle();
      do @(negedge clock); while (words_taken != words_queued || pending_verdicts.size() != 0);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [THR_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(negedge clock); while (!csr_took);
      csr_valid <= 1'b0;
   endtask

   int k_set[7]      = '{20, 1, 32, 0, 45, 63, 8};
   int corner_set[7] = '{150, 0, 65535, 100, 200, 65535, 40};
   int planar_set[7] = '{50, 0, 65535, 20, 80, 0, 40};

   initial begin : stimulus
      int rnd_words, phase, npts, span_xy, span_z, bx, by, bz, ncls, start;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, every function, invalid index, ignored code
      push_classify(0);
      push_word(FUNC_LOAD, 0, -524288, -524288, -524288, 'h000000);
      push_word(FUNC_LOAD, 1023, 524287, 524287, 524287, 'hFFFFFF);
      push_word(FUNC_LOAD, 0, 0, 0, 0, 'h5A3C81);
      push_word(FUNC_LOAD, 0, 1, 0, 0, 'hA5C37E);
      push_word(FUNC_LOAD, 0, -1, 0, 0, 'h123456);
      push_word(FUNC_LOAD, 0, 0, 0, 30, 'h808080);
      push_word(FUNC_UNUSED, 'h3FF, -1, -1, -1, 'hFFFFFF);
      for (int i = 0; i < 7; i++) push_classify(i);
      push_classify(1023);
      push_classify(6);
      push_word(FUNC_CLEAR, 0, 0, 0, 0, 0);
      push_classify(0);
      push_word(FUNC_LOAD, 0, 100, 100, 100, 'h010203);
      push_classify(0);
      push_classify(1);
      settle();

      // k of one and thresholds at zero on the same small frame
      write_reg(CSR_NEIGHBOR_COUNT, THR_W'(1));
      write_reg(CSR_CORNER_THRESHOLD, THR_W'(0));
      write_reg(CSR_PLANAR_THRESHOLD, THR_W'(0));
      write_reg(CSR_UNUSED, 16'hFFFF);
      push_classify(0);
      settle();

      // neighbour count far above the list depth
      write_reg(CSR_NEIGHBOR_COUNT, 16'hFFFF);
      write_reg(CSR_CORNER_THRESHOLD, THR_W'(150));
      write_reg(CSR_PLANAR_THRESHOLD, THR_W'(50));
      push_classify(0);
      push_classify(1);
      settle();

      // receiver holds off while classifies pile up
      push_word(FUNC_CLEAR, 0, 0, 0, 0, 0);
      for (int i = 0; i < 20; i++) push_point(0, 0, 0, 50, 200);
      settle();
      hold_asked++;
      for (int i = 0; i < 8; i++) push_classify($urandom_range(19));
      settle();

      // random frames, cycling the register settings between phases
      rnd_words = 0;
      phase = 0;
      while (rnd_words < RANDOM_WORDS) begin
         if (rnd_words >= phase * 80) begin
            settle();
            write_reg(CSR_NEIGHBOR_COUNT, THR_W'(k_set[phase % 7]));
            write_reg(CSR_CORNER_THRESHOLD, THR_W'(corner_set[phase % 7]));
            write_reg(CSR_PLANAR_THRESHOLD, THR_W'(planar_set[phase % 7]));
            calm = (phase == 3);
            phase++;
         end
         start = words_queued;
         if ($urandom_range(3) != 0) begin
            push_word(FUNC_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
            npts = $urandom_range(1, 40);
         end else begin
            npts = $urandom_range(0, 6);
         end
         span_xy = ($urandom_range(2) == 0) ? 2 : $urandom_range(10, 400);
         case ($urandom_range(2))
            0: span_z = $urandom_range(0, 40);
            1: span_z = $urandom_range(100, 500);
            default: span_z = $urandom_range(500, 4000);
         endcase
         bx = $urandom_range(0, 800000) - 400000;
         by = $urandom_range(0, 800000) - 400000;
         bz = $urandom_range(0, 800000) - 400000;
         for (int i = 0; i < npts; i++) push_point(bx, by, bz, span_xy, span_z);
         ncls = $urandom_range(1, 8);
         for (int i = 0; i < ncls; i++) begin
            case ($urandom_range(9))
               0: push_classify($urandom_range(1023));
               1: push_word(FUNC_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom);
               default: push_classify($urandom_range(frame_size + npts + 1));
            endcase
         end
         rnd_words += words_queued - start;
         // now and then the sender pauses until everything has come back, else until fewer than eight words wait
         if ($urandom_range(9) == 0) settle();
         else wait (request_words.size() < 8);
      end

      settle();
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

>>> sim.f
design/knnhr_pkg.sv
design/knnhr_ram.sv
design/knnhr_dist.sv
design/knnhr_list.sv
design/knn_height_roughness_classifier.sv
bench/tb.sv
